// ----- hdl/dtcsm_pkg.sv -----
package dtcsm_pkg;

  typedef struct packed {
    logic [4:0] code_index;
    logic       fault_present;
    logic       test_enabled;
    logic       clear_request;
    logic       cycle_ended;
  } item_t;

  typedef struct packed {
    logic [4:0]  code_id;
    logic [7:0]  status_byte;
    logic [1:0]  snapshot_state;
    logic [31:0] occurrence_count;
    logic [31:0] pending_count;
    logic [7:0]  aged_count;
  } result_t;

  typedef struct packed {
    item_t item;
    logic  out_of_range;
  } work_t;

  typedef struct packed {
    logic [15:0] settle_ticks;
    logic [7:0]  confirm_threshold;
    logic [7:0]  aging_limit;
    logic [7:0]  supported_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  status_bits;
    logic [15:0] settle_counter;
    logic        awaiting_first_result;
    logic        fault_seen;
    logic [7:0]  cycle_fault_counter;
    logic [1:0]  snapshot_phase;
    logic [31:0] occurrences;
    logic [31:0] pendings;
    logic [7:0]  aging_counter;
    logic [7:0]  aged_total;
  } entry_t;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_THRESHOLD = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AGING_LIMIT       = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SUPPORTED_MASK    = 8'd3;

  localparam logic [15:0] SETTLE_TICKS_RESET      = 16'd100;
  localparam logic [7:0]  CONFIRM_THRESHOLD_RESET = 8'd1;
  localparam logic [7:0]  AGING_LIMIT_RESET       = 8'd40;
  localparam logic [7:0]  SUPPORTED_MASK_RESET    = 8'hFF;

  localparam logic [7:0] B_TF     = 8'h01;
  localparam logic [7:0] B_TFTOC  = 8'h02;
  localparam logic [7:0] B_PEND   = 8'h04;
  localparam logic [7:0] B_CONF   = 8'h08;
  localparam logic [7:0] B_TNCSLC = 8'h10;
  localparam logic [7:0] B_TFSLC  = 8'h20;
  localparam logic [7:0] B_TNCTOC = 8'h40;
  localparam logic [7:0] CLEARED_STATUS = 8'h50;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  localparam logic [1:0] PHASE_NONE  = 2'd0;
  localparam logic [1:0] PHASE_FIRST = 2'd1;
  localparam logic [1:0] PHASE_LATER = 2'd2;

  localparam entry_t ENTRY_RESET = '{
    status_bits:           CLEARED_STATUS,
    settle_counter:        SETTLE_TICKS_RESET,
    awaiting_first_result: 1'b1,
    fault_seen:            1'b1,
    cycle_fault_counter:   8'd1,
    snapshot_phase:        PHASE_NONE,
    occurrences:           32'd0,
    pendings:              32'd0,
    aging_counter:         8'd0,
    aged_total:            8'd0
  };

endpackage

// ----- hdl/dtcsm_front.sv -----
module dtcsm_front #(
  parameter int NUM_CODES = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  dtcsm_pkg::item_t item,
  output logic           push,
  output dtcsm_pkg::work_t push_word,
  input  logic           queue_full
);
  import dtcsm_pkg::*;

  logic  stage_valid;
  work_t stage;
  work_t stage_next;
  logic  accept;

  assign item_stall = stage_valid && queue_full;
  assign accept     = item_valid && !item_stall;
  assign push       = stage_valid && !queue_full;
  assign push_word  = stage;

  always_comb begin
    stage_next.item         = item;
    stage_next.out_of_range = (32'(item.code_index) >= 32'(NUM_CODES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

endmodule

// ----- hdl/dtcsm_queue.sv -----
module dtcsm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dtcsm_pkg::work_t push_word,
  output logic           full,
  input  logic           pop,
  output dtcsm_pkg::work_t head,
  output logic           empty
);
  import dtcsm_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  work_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

// ----- hdl/dtcsm_back.sv -----
module dtcsm_back #(
  parameter int NUM_CODES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  dtcsm_pkg::cfg_t  cfg,
  input  logic             queue_empty,
  input  dtcsm_pkg::work_t head,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output dtcsm_pkg::result_t result
);
  import dtcsm_pkg::*;

  localparam int AW = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic           state;
  entry_t         code_mem [NUM_CODES];
  logic [NUM_CODES-1:0] entry_valid;
  entry_t         rd_entry;
  logic           rd_valid;
  work_t          cur;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic           can_out;
  logic           finish;
  logic           mem_we;
  entry_t         entry_next;
  result_t        result_next;

  assign rd_addr = AW'(head.item.code_index);
  assign wr_addr = AW'(cur.item.code_index);
  assign pop     = (state == ST_IDLE) && !queue_empty;
  assign can_out = !result_valid || !result_stall;
  assign finish  = (state == ST_CALC) && can_out;
  assign mem_we  = finish && !cur.out_of_range;

  always_comb begin
    entry_next = rd_valid ? rd_entry : ENTRY_RESET;
    if (entry_next.settle_counter < cfg.settle_ticks) begin
      entry_next.settle_counter = entry_next.settle_counter + 16'd1;
    end
    if (cur.item.test_enabled && entry_next.settle_counter >= cfg.settle_ticks) begin
      if (cur.item.fault_present) begin
        entry_next.status_bits = entry_next.status_bits | B_TF | B_TFTOC;
        if (!entry_next.fault_seen) begin
          entry_next.fault_seen = 1'b1;
          if (entry_next.occurrences != SAT32) begin
            entry_next.occurrences = entry_next.occurrences + 32'd1;
          end
          entry_next.cycle_fault_counter = entry_next.cycle_fault_counter + 8'd1;
          if (entry_next.cycle_fault_counter >= cfg.confirm_threshold) begin
            entry_next.cycle_fault_counter = 8'd0;
            entry_next.status_bits = entry_next.status_bits | B_PEND;
            if (entry_next.snapshot_phase == PHASE_NONE
                && (entry_next.status_bits & B_CONF) == 8'd0) begin
              entry_next.snapshot_phase = PHASE_FIRST;
            end else begin
              entry_next.snapshot_phase = PHASE_LATER;
            end
            if (entry_next.pendings != SAT32) begin
              entry_next.pendings = entry_next.pendings + 32'd1;
            end
          end
        end
        if (entry_next.awaiting_first_result) begin
          entry_next.awaiting_first_result = 1'b0;
          entry_next.status_bits = (entry_next.status_bits | B_TFSLC)
                                   & ~(B_TNCSLC | B_TNCTOC);
        end
      end else begin
        entry_next.status_bits = entry_next.status_bits & ~B_TF;
        entry_next.fault_seen  = 1'b0;
        if (entry_next.awaiting_first_result) begin
          entry_next.awaiting_first_result = 1'b0;
          entry_next.status_bits = entry_next.status_bits & ~(B_TNCSLC | B_TNCTOC);
        end
      end
    end
    if (cur.item.clear_request) begin
      entry_next.awaiting_first_result = 1'b1;
      entry_next.settle_counter        = 16'd0;
      entry_next.status_bits           = CLEARED_STATUS;
      entry_next.fault_seen            = 1'b0;
      entry_next.snapshot_phase        = PHASE_NONE;
      entry_next.occurrences           = 32'd0;
      entry_next.pendings              = 32'd0;
      entry_next.aging_counter         = 8'd0;
      entry_next.aged_total            = 8'd0;
    end
    if (cur.item.cycle_ended && (entry_next.status_bits & (B_TF | B_TFTOC)) == 8'd0) begin
      entry_next.aging_counter = entry_next.aging_counter + 8'd1;
      if (entry_next.aging_counter >= cfg.aging_limit) begin
        entry_next.aging_counter = 8'd0;
        entry_next.aged_total    = entry_next.aged_total + 8'd1;
        entry_next.status_bits   = 8'd0;
      end
    end
  end

  always_comb begin
    result_next.code_id = cur.item.code_index;
    if (cur.out_of_range) begin
      result_next.status_byte      = 8'd0;
      result_next.snapshot_state   = 2'd0;
      result_next.occurrence_count = 32'd0;
      result_next.pending_count    = 32'd0;
      result_next.aged_count       = 8'd0;
    end else begin
      result_next.status_byte      = entry_next.status_bits & cfg.supported_mask;
      result_next.snapshot_state   = entry_next.snapshot_phase;
      result_next.occurrence_count = entry_next.occurrences;
      result_next.pending_count    = entry_next.pendings;
      result_next.aged_count       = entry_next.aged_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      entry_valid  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (can_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (mem_we) begin
        entry_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      code_mem[wr_addr] <= entry_next;
    end
    if (pop) begin
      rd_entry <= code_mem[rd_addr];
      rd_valid <= entry_valid[rd_addr];
      cur      <= head;
    end
    if (finish) begin
      result <= result_next;
    end
  end

  a_write_in_calc: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_CALC)
    else $error("table write outside evaluation");

  a_pop_to_calc: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == ST_CALC)
    else $error("popped word not evaluated");

  a_result_from_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_CALC)
    else $error("result raised without evaluation");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) && $past(cur.out_of_range) |->
      result.status_byte == 8'd0 && result.occurrence_count == 32'd0
      && result.pending_count == 32'd0 && result.aged_count == 8'd0)
    else $error("unknown code gave non-zero result");

endmodule

// ----- hdl/dtc_status_manager.sv -----
// path: a result word passes the front stage register, the two-entry queue, the table
// read registers and the result register; the back end takes no new item until the
// last one is written back to the per-code table (registered read, then write-back)
// reset: rst is synchronous; every code reads as freshly reset through valid bits,
// so the table needs no clearing pass and items are taken from the first cycle
module dtc_status_manager #(
  parameter int NUM_CODES = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  dtcsm_pkg::item_t                     item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output dtcsm_pkg::result_t                   result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dtcsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dtcsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dtcsm_pkg::*;

  cfg_t  cfg;
  logic  push;
  work_t push_word;
  logic  queue_full;
  logic  queue_empty;
  logic  pop;
  work_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks      <= SETTLE_TICKS_RESET;
      cfg.confirm_threshold <= CONFIRM_THRESHOLD_RESET;
      cfg.aging_limit       <= AGING_LIMIT_RESET;
      cfg.supported_mask    <= SUPPORTED_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETTLE_TICKS:      cfg.settle_ticks      <= cfg_data;
        REG_CONFIRM_THRESHOLD: cfg.confirm_threshold <= cfg_data[7:0];
        REG_AGING_LIMIT:       cfg.aging_limit       <= cfg_data[7:0];
        REG_SUPPORTED_MASK:    cfg.supported_mask    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  dtcsm_front #(
    .NUM_CODES (NUM_CODES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_word  (push_word),
    .queue_full (queue_full)
  );

  dtcsm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (queue_full),
    .pop       (pop),
    .head      (head),
    .empty     (queue_empty)
  );

  dtcsm_back #(
    .NUM_CODES (NUM_CODES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .queue_empty  (queue_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import dtcsm_pkg::*;

  localparam int CODES      = 32;
  localparam int QUIET_MAX  = 2000;
  localparam int SETTLE_GAP = 6;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } eval_row_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_stall;
  item_t                  item         = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  dtc_status_manager #(
    .NUM_CODES(CODES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the per-code table and registers
  entry_t    code_tab [CODES];
  cfg_t      cfg_now = '{SETTLE_TICKS_RESET, CONFIRM_THRESHOLD_RESET,
                         AGING_LIMIT_RESET, SUPPORTED_MASK_RESET};
  eval_row_t evals_todo [$];
  result_t   reports_due [$];
  result_t   due;
  int        failures = 0;
  int        quiet = 0;
  int        stall_run = 0;
  int        stall_mode = 0;
  bit        fault_level [CODES];
  logic [4:0] hot_codes [3];

  function automatic result_t advance_code(item_t it);
    entry_t  e;
    result_t r;
    e = code_tab[it.code_index];
    if (e.settle_counter < cfg_now.settle_ticks) e.settle_counter = e.settle_counter + 16'd1;
    if (it.test_enabled && e.settle_counter >= cfg_now.settle_ticks) begin
      if (it.fault_present) begin
        e.status_bits = e.status_bits | B_TF | B_TFTOC;
        if (!e.fault_seen) begin
          e.fault_seen = 1'b1;
          if (e.occurrences != SAT32) e.occurrences = e.occurrences + 32'd1;
          e.cycle_fault_counter = e.cycle_fault_counter + 8'd1;
          if (e.cycle_fault_counter >= cfg_now.confirm_threshold) begin
            e.cycle_fault_counter = 8'd0;
            e.status_bits = e.status_bits | B_PEND;
            if (e.snapshot_phase == PHASE_NONE && (e.status_bits & B_CONF) == 8'd0)
              e.snapshot_phase = PHASE_FIRST;
            else
              e.snapshot_phase = PHASE_LATER;
            if (e.pendings != SAT32) e.pendings = e.pendings + 32'd1;
          end
        end
        if (e.awaiting_first_result) begin
          e.awaiting_first_result = 1'b0;
          e.status_bits = (e.status_bits | B_TFSLC) & ~(B_TNCSLC | B_TNCTOC);
        end
      end else begin
        e.status_bits = e.status_bits & ~B_TF;
        e.fault_seen = 1'b0;
        if (e.awaiting_first_result) begin
          e.awaiting_first_result = 1'b0;
          e.status_bits = e.status_bits & ~(B_TNCSLC | B_TNCTOC);
        end
      end
    end
    if (it.clear_request) begin
      e.awaiting_first_result = 1'b1;
      e.settle_counter = 16'd0;
      e.status_bits = CLEARED_STATUS;
      e.fault_seen = 1'b0;
      e.snapshot_phase = PHASE_NONE;
      e.occurrences = 32'd0;
      e.pendings = 32'd0;
      e.aging_counter = 8'd0;
      e.aged_total = 8'd0;
    end
    if (it.cycle_ended && (e.status_bits & (B_TF | B_TFTOC)) == 8'd0) begin
      e.aging_counter = e.aging_counter + 8'd1;
      if (e.aging_counter >= cfg_now.aging_limit) begin
        e.aging_counter = 8'd0;
        e.aged_total = e.aged_total + 8'd1;
        e.status_bits = 8'd0;
      end
    end
    code_tab[it.code_index] = e;
    r.code_id          = it.code_index;
    r.status_byte      = e.status_bits & cfg_now.supported_mask;
    r.snapshot_state   = e.snapshot_phase;
    r.occurrence_count = e.occurrences;
    r.pending_count    = e.pendings;
    r.aged_count       = e.aged_total;
    return r;
  endfunction

  function automatic item_t eval_item(logic [4:0] code, bit flt, bit en, bit clr, bit cyc);
    return {code, flt, en, clr, cyc};
  endfunction

  function automatic void add_row(item_t s, bit typed, result_t w);
    eval_row_t row;
    row.stim  = s;
    row.typed = typed;
    row.want  = w;
    evals_todo.push_back(row);
  endfunction

  // mostly fault sequences on a few hot codes, the rest spread and noisy
  task automatic build_random(int n);
    logic [4:0] code;
    bit         flt;
    for (int k = 0; k < 3; k++) hot_codes[k] = 5'($urandom_range(0, CODES - 1));
    for (int i = 0; i < n; i++) begin
      code = ($urandom_range(0, 9) < 7) ? hot_codes[$urandom_range(0, 2)]
                                        : 5'($urandom_range(0, CODES - 1));
      if ($urandom_range(0, 9) < 3) fault_level[code] = ~fault_level[code];
      flt = ($urandom_range(0, 9) == 0) ? 1'($urandom) : fault_level[code];
      add_row(eval_item(code, flt, $urandom_range(0, 9) != 0, $urandom_range(0, 29) == 0,
                        $urandom_range(0, 4) == 0), 1'b0, '0);
    end
  endtask

  task automatic send_rows();
    eval_row_t row;
    result_t   pred;
    int        burst;
    int        gap;
    burst = 0;
    while (evals_todo.size() != 0) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      row = evals_todo.pop_front();
      item       <= row.stim;
      item_valid <= 1'b1;
      do @(posedge clk); while (item_stall);
      pred = advance_code(row.stim);
      reports_due.push_back(row.typed ? row.want : pred);
      burst--;
      @(negedge clk);
    end
    item_valid <= 1'b0;
  endtask

  task automatic drain();
    while (reports_due.size() != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  task automatic program_regs(logic [15:0] settle, logic [7:0] thr, logic [7:0] age,
                              logic [7:0] mask);
    logic [CFG_INDEX_W-1:0] regs [4];
    logic [CFG_DATA_W-1:0]  vals [4];
    regs[0] = REG_SETTLE_TICKS;      vals[0] = settle;
    regs[1] = REG_CONFIRM_THRESHOLD; vals[1] = {8'd0, thr};
    regs[2] = REG_AGING_LIMIT;       vals[2] = {8'd0, age};
    regs[3] = REG_SUPPORTED_MASK;    vals[3] = {8'd0, mask};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (regs[i])
        REG_SETTLE_TICKS:      cfg_now.settle_ticks      = vals[i];
        REG_CONFIRM_THRESHOLD: cfg_now.confirm_threshold = vals[i][7:0];
        REG_AGING_LIMIT:       cfg_now.aging_limit       = vals[i][7:0];
        REG_SUPPORTED_MASK:    cfg_now.supported_mask    = vals[i][7:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // receiver back-pressure: free runs, random stalls and a periodic pattern
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run  = $urandom_range(4, 40);
    end
    stall_run--;
    case (stall_mode)
      0:       result_stall <= 1'b0;
      1:       result_stall <= ($urandom_range(0, 2) == 0);
      default: result_stall <= ((stall_run % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (reports_due.size() == 0) begin
        $error("unexpected result word for code %0d", result.code_id);
        failures++;
      end else begin
        due = reports_due.pop_front();
        if (result.code_id !== due.code_id) begin
          $error("code_id: expected %0d, got %0d", due.code_id, result.code_id);
          failures++;
        end
        if (result.status_byte !== due.status_byte) begin
          $error("status_byte: expected %h, got %h", due.status_byte, result.status_byte);
          failures++;
        end
        if (result.snapshot_state !== due.snapshot_state) begin
          $error("snapshot_state: expected %0d, got %0d", due.snapshot_state,
                 result.snapshot_state);
          failures++;
        end
        if (result.occurrence_count !== due.occurrence_count) begin
          $error("occurrence_count: expected %0d, got %0d", due.occurrence_count,
                 result.occurrence_count);
          failures++;
        end
        if (result.pending_count !== due.pending_count) begin
          $error("pending_count: expected %0d, got %0d", due.pending_count,
                 result.pending_count);
          failures++;
        end
        if (result.aged_count !== due.aged_count) begin
          $error("aged_count: expected %0d, got %0d", due.aged_count, result.aged_count);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < CODES; c++) begin
      code_tab[c]    = ENTRY_RESET;
      fault_level[c] = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: code, fault, enable, clear, cycle ended
    add_row(eval_item(5'd0, 0, 0, 0, 0), 1'b1,
            {5'd0, CLEARED_STATUS, PHASE_NONE, 32'd0, 32'd0, 8'd0});
    add_row(eval_item(5'd31, 1, 1, 0, 0), 1'b1,
            {5'd31, B_TFSLC | B_TFTOC | B_TF, PHASE_NONE, 32'd0, 32'd0, 8'd0});
    add_row(eval_item(5'd31, 0, 1, 0, 0), 1'b0, '0);
    add_row(eval_item(5'd31, 1, 1, 0, 0), 1'b0, '0);
    add_row(eval_item(5'd31, 1, 1, 0, 0), 1'b0, '0);
    add_row(eval_item(5'd31, 0, 0, 0, 1), 1'b0, '0);
    add_row(eval_item(5'd31, 1, 1, 1, 0), 1'b1,
            {5'd31, CLEARED_STATUS, PHASE_NONE, 32'd0, 32'd0, 8'd0});
    add_row(eval_item(5'd31, 1, 1, 0, 0), 1'b0, '0);
    add_row(eval_item(5'd9, 0, 0, 0, 1), 1'b1,
            {5'd9, CLEARED_STATUS, PHASE_NONE, 32'd0, 32'd0, 8'd0});
    add_row(eval_item(5'd9, 0, 1, 0, 1), 1'b0, '0);
    add_row(eval_item(5'd16, 1, 1, 1, 1), 1'b0, '0);
    add_row(eval_item(5'd16, 0, 1, 0, 0), 1'b0, '0);
    add_row(eval_item(5'd1, 1, 1, 0, 0), 1'b0, '0);
    add_row(eval_item(5'd1, 0, 1, 0, 0), 1'b0, '0);
    add_row(eval_item(5'd1, 1, 1, 0, 0), 1'b0, '0);
    add_row(eval_item(5'd2, 1, 0, 0, 0), 1'b0, '0);
    add_row(eval_item(5'd30, 1, 1, 0, 1), 1'b0, '0);
    build_random(150);
    send_rows();

    drain();
    program_regs(16'd0, 8'd0, 8'd0, 8'hFF);
    build_random(170);
    send_rows();

    drain();
    program_regs(16'hFFFF, 8'hFF, 8'hFF, 8'h00);
    build_random(60);
    send_rows();

    drain();
    program_regs(16'd2, 8'd2, 8'd3, 8'($urandom));
    build_random(170);
    send_rows();

    drain();
    program_regs(16'd1, 8'd1, 8'd1, 8'hFF);
    build_random(170);
    send_rows();

    drain();
    program_regs(16'd5, 8'd3, 8'd2, 8'h5A);
    build_random(130);
    send_rows();

    drain();
    if (failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
